### rtl/bgc_pkg.sv
// Shared types and constants for the button gesture classifier.
`timescale 1ns / 1ps

package bgc_pkg;

  localparam int TIME_BITS_DEF = 16;
  localparam int CFG_W         = 16;
  localparam int APB_DW        = 32;
  localparam int APB_AW        = 3;

  // register map, byte addresses 4*index
  localparam logic [APB_AW-1:0] ADDR_DC_WINDOW  = 3'd0;
  localparam logic [APB_AW-1:0] ADDR_LONG_PRESS = 3'd4;

  localparam logic [CFG_W-1:0] DC_WINDOW_RST  = 16'd300;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

  localparam logic CMD_TICK      = 1'b0;
  localparam logic CMD_PIN       = 1'b1;
  localparam logic LEVEL_PRESSED = 1'b0;

  // result queue
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  typedef enum logic [2:0] {
    GEST_PRESSED  = 3'd0,
    GEST_RELEASED = 3'd1,
    GEST_CLICKED  = 3'd2,
    GEST_DOUBLE   = 3'd3,
    GEST_LONG     = 3'd4
  } gesture_t;

  typedef struct packed {
    gesture_t gesture;
    logic     last_of_run;
  } result_t;

endpackage

### rtl/bgc_if.sv
// Valid/ready channel interfaces for input items and result words.
`timescale 1ns / 1ps

interface bgc_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic pin_level;

  modport source(output valid, output cmd, output pin_level, input ready);
  modport sink(input valid, input cmd, input pin_level, output ready);
endinterface

interface bgc_out_if;
  logic              valid;
  logic              ready;
  bgc_pkg::gesture_t gesture;
  logic              last_of_run;

  modport source(output valid, output gesture, output last_of_run, input ready);
  modport sink(input valid, input gesture, input last_of_run, output ready);
endinterface

### rtl/button_gesture_classifier.sv
// Top level: button gesture classifier with APB register port and result queue.
`timescale 1ns / 1ps

// Turns millisecond ticks and pin changes into gesture words. An input word is
// accepted in any cycle in which the four-word result queue has room for two
// words, so ticks and presses go through at one per cycle while it has room;
// each result is written to the queue and reaches the output behind any older
// words. Each press gives one word, each expiring long-press countdown one word
// and each release two words (clicked or double clicked, then released). The
// single output port sends one word per cycle while result.ready is high.
// Registers: double_click_window at byte address 0, long_press_time at 4; write
// them only while no results are outstanding.
module button_gesture_classifier #(
  parameter int TIME_BITS = bgc_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  bgc_in_if.sink                      item,
  bgc_out_if.source                   result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bgc_pkg::APB_AW-1:0]  paddr,
  input  logic [bgc_pkg::APB_DW-1:0]  pwdata,
  output logic [bgc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int CMP_W = (TIME_BITS > bgc_pkg::CFG_W) ? TIME_BITS : bgc_pkg::CFG_W;

  // config registers
  logic [bgc_pkg::CFG_W-1:0] double_click_window;
  logic [bgc_pkg::CFG_W-1:0] long_press_time;

  // classifier state
  logic [TIME_BITS-1:0]      since_press_ms, since_press_ms_next;
  logic [bgc_pkg::CFG_W-1:0] hold_countdown, hold_countdown_next;
  logic                      hold_armed, hold_armed_next;
  logic                      double_seen, double_seen_next;

  // result queue
  bgc_pkg::result_t          rq [bgc_pkg::RQ_DEPTH];
  logic [bgc_pkg::RQ_AW-1:0] wr_ptr, rd_ptr;
  logic [bgc_pkg::RQ_CW-1:0] rq_count, rq_count_next;

  logic                      item_acc, res_acc, cfg_wr;
  logic [1:0]                n_push;
  bgc_pkg::result_t          word0, word1;
  logic                      is_double;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign item_acc = item.valid && item.ready;
  assign res_acc  = result.valid && result.ready;

  // room for a release's two words
  assign item.ready = (rq_count <= bgc_pkg::RQ_CW'(bgc_pkg::RQ_DEPTH - 2));

  assign result.valid       = (rq_count != '0);
  assign result.gesture     = rq[rd_ptr].gesture;
  assign result.last_of_run = rq[rd_ptr].last_of_run;

  // low address bits select a byte lane and are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      double_click_window <= bgc_pkg::DC_WINDOW_RST;
      long_press_time     <= bgc_pkg::LONG_PRESS_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == bgc_pkg::ADDR_LONG_PRESS[2]) begin
        long_press_time <= pwdata[bgc_pkg::CFG_W-1:0];
      end else begin
        double_click_window <= pwdata[bgc_pkg::CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == bgc_pkg::ADDR_LONG_PRESS[2]) begin
      prdata = bgc_pkg::APB_DW'(long_press_time);
    end else begin
      prdata = bgc_pkg::APB_DW'(double_click_window);
    end
  end

  assign is_double = CMP_W'(since_press_ms) < CMP_W'(double_click_window);

  always_comb begin
    since_press_ms_next = since_press_ms;
    hold_countdown_next = hold_countdown;
    hold_armed_next     = hold_armed;
    double_seen_next    = double_seen;
    n_push              = 2'd0;
    word0               = '{gesture: bgc_pkg::GEST_PRESSED, last_of_run: 1'b1};
    word1               = '{gesture: bgc_pkg::GEST_RELEASED, last_of_run: 1'b1};
    if (item_acc) begin
      if (item.cmd == bgc_pkg::CMD_TICK) begin
        if (since_press_ms != {TIME_BITS{1'b1}}) begin
          since_press_ms_next = since_press_ms + 1'b1;
        end
        if (hold_armed) begin
          if (hold_countdown <= bgc_pkg::CFG_W'(1)) begin
            hold_countdown_next = '0;
            hold_armed_next     = 1'b0;
            word0.gesture       = bgc_pkg::GEST_LONG;
            n_push              = 2'd1;
          end else begin
            hold_countdown_next = hold_countdown - 1'b1;
          end
        end
      end else if (item.pin_level == bgc_pkg::LEVEL_PRESSED) begin
        n_push = 2'd1;
        if (is_double) begin
          double_seen_next = 1'b1;
          hold_armed_next  = 1'b0;
        end else begin
          double_seen_next    = 1'b0;
          hold_countdown_next = long_press_time;
          hold_armed_next     = 1'b1;
        end
        since_press_ms_next = '0;
      end else begin
        word0.gesture     = double_seen ? bgc_pkg::GEST_DOUBLE : bgc_pkg::GEST_CLICKED;
        word0.last_of_run = 1'b0;
        hold_armed_next   = 1'b0;
        n_push            = 2'd2;
      end
    end
    rq_count_next = rq_count + bgc_pkg::RQ_CW'(n_push) - bgc_pkg::RQ_CW'(res_acc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      since_press_ms <= {TIME_BITS{1'b1}};
      hold_countdown <= '0;
      hold_armed     <= 1'b0;
      double_seen    <= 1'b0;
      wr_ptr         <= '0;
      rd_ptr         <= '0;
      rq_count       <= '0;
    end else begin
      since_press_ms <= since_press_ms_next;
      hold_countdown <= hold_countdown_next;
      hold_armed     <= hold_armed_next;
      double_seen    <= double_seen_next;
      rq_count       <= rq_count_next;
      wr_ptr         <= wr_ptr + bgc_pkg::RQ_AW'(n_push);
      if (res_acc) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // queue storage, no reset
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      rq[wr_ptr] <= word0;
    end
    if (n_push == 2'd2) begin
      rq[wr_ptr + 1'b1] <= word1;
    end
  end

endmodule

### rtl/bgc_checker.sv
// Port-level checks for the button gesture classifier, bound to the top level.
`timescale 1ns / 1ps

module bgc_checker (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input bgc_pkg::gesture_t res_gesture,
  input logic              res_last,
  input logic              pready
);

  // queue is empty right after reset
  ast_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // only clicked and double clicked are followed by another word of the same run
  ast_last_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_last == !(res_gesture == bgc_pkg::GEST_CLICKED ||
                                 res_gesture == bgc_pkg::GEST_DOUBLE)))
    else $error("last_of_run does not match gesture");

  // the released word is queued with its click, so it follows at once
  ast_release_follows: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready && (res_gesture == bgc_pkg::GEST_CLICKED ||
                                res_gesture == bgc_pkg::GEST_DOUBLE))
    |=> (res_valid && res_gesture == bgc_pkg::GEST_RELEASED))
    else $error("released word missing after click");

  ast_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_gesture) && $stable(res_last)))
    else $error("stalled result word changed");

  ast_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind button_gesture_classifier bgc_checker u_bgc_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_gesture (result.gesture),
  .res_last    (result.last_of_run),
  .pready      (pready)
);
